/* rtl/core/tilt_imbalance_classifier_unit_assert.svh */
// Assertion macros for the tilt imbalance classifier.
// Expects signals named clk and rst in the module that uses them.
`ifndef TILT_IMBALANCE_CLASSIFIER_UNIT_ASSERT_SVH
`define TILT_IMBALANCE_CLASSIFIER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TIC_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define TIC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define TIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tic_pkg.sv */
// Shared types and constants for the tilt imbalance classifier.
// No dependencies; the rtl files refer to it by scoped names, the verif files import it.
`timescale 1ns / 1ps
`default_nettype none

package tic_pkg;

  localparam int ANGLE_W = 16;
  localparam int THR_W   = 16;
  localparam int RUN_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0] LR_THRESHOLD_RST = 16'd240;
  localparam logic [THR_W-1:0] FH_THRESHOLD_RST = 16'd240;
  localparam logic [RUN_W-1:0] MIN_RUN_RST      = 8'd10;
  localparam logic [RUN_W-1:0] RUN_MAX          = 8'd255;

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_LEFT   = 3'd1,
    ST_RIGHT  = 3'd2,
    ST_FRONT  = 3'd3,
    ST_HIND   = 3'd4
  } tilt_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LR_THRESHOLD = 2'd0,
    CFG_FH_THRESHOLD = 2'd1,
    CFG_MIN_RUN      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] lr_threshold;
    logic [THR_W-1:0] fh_threshold;
    logic [RUN_W-1:0] min_run;
  } cfg_t;

  typedef struct packed {
    tilt_state_t state;
    logic        entered;
    logic        captured;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/tic_ifs.sv */
// Channel interfaces: sample input, classification result, register write.
// Depends on tic_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface tic_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [tic_pkg::ANGLE_W-1:0]  roll_sample;
  logic signed [tic_pkg::ANGLE_W-1:0]  pitch_sample;
  logic                                window_start;

  modport source (output valid, output roll_sample, output pitch_sample,
                  output window_start, input ready);
  modport sink (input valid, input roll_sample, input pitch_sample,
                input window_start, output ready);
endinterface

interface tic_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] balance_state;
  logic       entered_imbalance;
  logic       baseline_captured;

  modport source (output valid, output balance_state, output entered_imbalance,
                  output baseline_captured, input ready);
  modport sink (input valid, input balance_state, input entered_imbalance,
                input baseline_captured, output ready);
endinterface

interface tic_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tic_pkg::CFG_IDX_W-1:0]     index;
  logic [tic_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tic_cfg_regs.sv */
// Configuration register file: thresholds and minimum run length.
// Depends on tic_pkg and tic_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module tic_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  tic_cfg_if.sink          cfg,
  output tic_pkg::cfg_t    regs
);

  tic_pkg::cfg_t regs_next;

  // Writes always complete in one beat
  assign cfg.ready = 1'b1;

  // Decode the register index
  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (tic_pkg::cfg_idx_t'(cfg.index))
        tic_pkg::CFG_LR_THRESHOLD: regs_next.lr_threshold = cfg.data;
        tic_pkg::CFG_FH_THRESHOLD: regs_next.fh_threshold = cfg.data;
        tic_pkg::CFG_MIN_RUN:      regs_next.min_run = cfg.data[tic_pkg::RUN_W-1:0];
        default:                   regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lr_threshold <= tic_pkg::LR_THRESHOLD_RST;
      regs.fh_threshold <= tic_pkg::FH_THRESHOLD_RST;
      regs.min_run      <= tic_pkg::MIN_RUN_RST;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tic_classifier.sv */
// Baseline, run counters and state decision for one sample per step.
// Depends on tic_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_imbalance_classifier_unit_assert.svh"

module tic_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               step,
  input  wire logic signed [tic_pkg::ANGLE_W-1:0] roll,
  input  wire logic signed [tic_pkg::ANGLE_W-1:0] pitch,
  input  wire logic                               window_start,
  input  tic_pkg::cfg_t                           regs,
  output tic_pkg::result_t                        res
);

  logic signed [tic_pkg::ANGLE_W-1:0] roll_base;
  logic signed [tic_pkg::ANGLE_W-1:0] pitch_base;
  logic [tic_pkg::RUN_W-1:0]          lr_run;
  logic [tic_pkg::RUN_W-1:0]          fh_run;
  logic                               lr_negative;
  logic                               fh_negative;
  tic_pkg::tilt_state_t               prev_state;

  logic signed [tic_pkg::ANGLE_W:0]   lr_off;
  logic signed [tic_pkg::ANGLE_W:0]   fh_off;
  logic [tic_pkg::ANGLE_W:0]          lr_mag;
  logic [tic_pkg::ANGLE_W:0]          fh_mag;
  logic                               lr_over;
  logic                               fh_over;
  logic [tic_pkg::RUN_W-1:0]          lr_run_next;
  logic [tic_pkg::RUN_W-1:0]          fh_run_next;
  logic                               lr_negative_next;
  logic                               fh_negative_next;
  tic_pkg::tilt_state_t               cur;

  // Offsets from baseline, exact in 17 bits, and their magnitudes
  always_comb begin
    lr_off = {roll[tic_pkg::ANGLE_W-1], roll} - {roll_base[tic_pkg::ANGLE_W-1], roll_base};
    fh_off = {pitch[tic_pkg::ANGLE_W-1], pitch}
           - {pitch_base[tic_pkg::ANGLE_W-1], pitch_base};
    lr_mag = lr_off[tic_pkg::ANGLE_W] ? $unsigned(-lr_off) : $unsigned(lr_off);
    fh_mag = fh_off[tic_pkg::ANGLE_W] ? $unsigned(-fh_off) : $unsigned(fh_off);
    lr_over = lr_mag > {1'b0, regs.lr_threshold};
    fh_over = fh_mag > {1'b0, regs.fh_threshold};
  end

  // Advance saturating run counters, clear them within the limit, keep sign of last over-limit offset
  always_comb begin
    lr_run_next      = '0;
    fh_run_next      = '0;
    lr_negative_next = lr_negative;
    fh_negative_next = fh_negative;
    if (lr_over) begin
      lr_negative_next = lr_off[tic_pkg::ANGLE_W];
      lr_run_next = (lr_run == tic_pkg::RUN_MAX) ? lr_run : lr_run + 1'b1;
    end
    if (fh_over) begin
      fh_negative_next = fh_off[tic_pkg::ANGLE_W];
      fh_run_next = (fh_run == tic_pkg::RUN_MAX) ? fh_run : fh_run + 1'b1;
    end
  end

  // Pick the state: left-right wins ties against front-hind
  always_comb begin
    if (lr_run_next >= regs.min_run && lr_run_next >= fh_run_next) begin
      cur = lr_negative_next ? tic_pkg::ST_LEFT : tic_pkg::ST_RIGHT;
    end else if (fh_run_next >= regs.min_run) begin
      cur = fh_negative_next ? tic_pkg::ST_FRONT : tic_pkg::ST_HIND;
    end else begin
      cur = tic_pkg::ST_NORMAL;
    end
  end

  // Result of this step
  always_comb begin
    if (window_start) begin
      res.state    = tic_pkg::ST_NORMAL;
      res.entered  = 1'b0;
      res.captured = 1'b1;
    end else begin
      res.state    = cur;
      res.entered  = (cur != prev_state) && (cur != tic_pkg::ST_NORMAL);
      res.captured = 1'b0;
    end
  end

  // Commit tracking state when the step is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_base   <= '0;
      pitch_base  <= '0;
      lr_run      <= '0;
      fh_run      <= '0;
      lr_negative <= 1'b0;
      fh_negative <= 1'b0;
      prev_state  <= tic_pkg::ST_NORMAL;
    end else if (step) begin
      if (window_start) begin
        roll_base   <= roll;
        pitch_base  <= pitch;
        lr_run      <= '0;
        fh_run      <= '0;
        lr_negative <= 1'b0;
        fh_negative <= 1'b0;
        prev_state  <= tic_pkg::ST_NORMAL;
      end else begin
        lr_run      <= lr_run_next;
        fh_run      <= fh_run_next;
        lr_negative <= lr_negative_next;
        fh_negative <= fh_negative_next;
        prev_state  <= cur;
      end
    end
  end

  `TIC_ASSERT_NEXT(a_window_clears, step && window_start, lr_run == '0 && fh_run == '0 && prev_state == tic_pkg::ST_NORMAL, "window start did not clear tracking state")
  `TIC_ASSERT_IMPL(a_state_needs_run, step && !window_start && cur != tic_pkg::ST_NORMAL, lr_run_next >= regs.min_run || fh_run_next >= regs.min_run, "imbalance declared without a full run")

endmodule

`default_nettype wire

/* rtl/core/tilt_imbalance_classifier_unit.sv */
// Top level of the tilt imbalance classifier: input register, classifier,
// result register. Depends on tic_pkg, tic_ifs, tic_cfg_regs, tic_classifier.
//
//   port     dir  beat carries
//   sample   in   roll_sample, pitch_sample, window_start
//   result   out  balance_state, entered_imbalance, baseline_captured
//   cfg      in   index (0 lr_threshold, 1 fh_threshold, 2 min_run), data
//
// One result per sample; one sample per cycle is sustained while result is
// not stalled, set by the single classifier step between the input and
// result registers. rst is synchronous and restores the register reset
// values, a zero baseline and cleared run counters. A stalled result holds
// the result register and then the input register; cfg writes take one beat.
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_imbalance_classifier_unit_assert.svh"

module tilt_imbalance_classifier_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  tic_sample_if.sink    sample,
  tic_result_if.source  result,
  tic_cfg_if.sink       cfg
);

  logic                               s1_valid;
  logic signed [tic_pkg::ANGLE_W-1:0] s1_roll;
  logic signed [tic_pkg::ANGLE_W-1:0] s1_pitch;
  logic                               s1_window_start;
  logic                               s1_advance;
  logic                               out_valid;
  tic_pkg::result_t                   out_res;
  tic_pkg::result_t                   res;
  tic_pkg::cfg_t                      regs;

  tic_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Move the held sample on when the result register is free or draining
  assign s1_advance   = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_roll         <= sample.roll_sample;
      s1_pitch        <= sample.pitch_sample;
      s1_window_start <= sample.window_start;
    end
  end

  tic_classifier u_classifier (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_advance),
    .roll         (s1_roll),
    .pitch        (s1_pitch),
    .window_start (s1_window_start),
    .regs         (regs),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.balance_state     = out_res.state;
  assign result.entered_imbalance = out_res.entered;
  assign result.baseline_captured = out_res.captured;

  `TIC_ASSERT_IMPL(a_baseline_result, out_valid && out_res.captured, out_res.state == tic_pkg::ST_NORMAL && !out_res.entered, "baseline beat carries a state")
  `TIC_ASSERT_IMPL(a_entered_abnormal, out_valid && out_res.entered, out_res.state != tic_pkg::ST_NORMAL, "entry flagged on normal state")
  `TIC_ASSERT_NEXT(a_s1_held, s1_valid && !s1_advance, s1_valid, "held sample dropped")
  `TIC_ASSERT_HOLDS(a_no_overrun, !(sample.valid && sample.ready && s1_valid && out_valid && !result.ready), "sample taken while pipeline full")

endmodule

`default_nettype wire

/* verif/tic_balance_checker.sv */
// Scoreboard for the tilt imbalance classifier: watches the sample, result and
// register channels, predicts each verdict and compares it field by field.
// Depends on tic_pkg and the channel interfaces in tic_ifs.
`timescale 1ns / 1ps

module tic_balance_checker (
  input  logic   clk,
  input  logic   rst,
  tic_sample_if  sample,
  tic_result_if  result,
  tic_cfg_if     cfg,
  output int     outstanding,
  output int     mismatches
);
  import tic_pkg::*;

  // Predictor state: limits, window baseline, run counters, last signs and verdict
  cfg_t                      regs;
  logic signed [ANGLE_W-1:0] roll_ref;
  logic signed [ANGLE_W-1:0] pitch_ref;
  logic [RUN_W-1:0]          lr_count;
  logic [RUN_W-1:0]          fh_count;
  logic                      lr_neg;
  logic                      fh_neg;
  tilt_state_t               held_state;
  result_t                   predicted_states[$];
  int                        mismatch_tally = 0;

  assign mismatches = mismatch_tally;

  // Advance one axis run counter: count over-limit offsets, saturate, keep sign, clear otherwise
  task automatic bump_run(input logic signed [ANGLE_W:0] offset,
                          input logic [THR_W-1:0] limit,
                          inout logic [RUN_W-1:0] run, inout logic neg);
    logic [ANGLE_W:0] mag;
    mag = offset[ANGLE_W] ? -offset : offset;
    if (mag > {1'b0, limit}) begin
      neg = offset[ANGLE_W];
      if (run != RUN_MAX) run = run + 1'b1;
    end else begin
      run = '0;
    end
  endtask

  // Classify one sample and update the predictor state
  task automatic classify_tilt(input logic signed [ANGLE_W-1:0] roll,
                               input logic signed [ANGLE_W-1:0] pitch,
                               input logic ws, output result_t verdict);
    tilt_state_t st;
    st = ST_NORMAL;
    verdict = '0;
    if (ws) begin
      // capture a new baseline and restart the window
      roll_ref   = roll;
      pitch_ref  = pitch;
      lr_count   = '0;
      fh_count   = '0;
      lr_neg     = 1'b0;
      fh_neg     = 1'b0;
      held_state = ST_NORMAL;
      verdict.state    = ST_NORMAL;
      verdict.entered  = 1'b0;
      verdict.captured = 1'b1;
    end else begin
      bump_run({roll[ANGLE_W-1], roll} - {roll_ref[ANGLE_W-1], roll_ref},
               regs.lr_threshold, lr_count, lr_neg);
      bump_run({pitch[ANGLE_W-1], pitch} - {pitch_ref[ANGLE_W-1], pitch_ref},
               regs.fh_threshold, fh_count, fh_neg);
      // left-right wins ties against front-hind
      if (lr_count >= regs.min_run && lr_count >= fh_count) begin
        st = lr_neg ? ST_LEFT : ST_RIGHT;
      end else if (fh_count >= regs.min_run) begin
        st = fh_neg ? ST_FRONT : ST_HIND;
      end
      verdict.state    = st;
      verdict.entered  = (st != held_state) && (st != ST_NORMAL);
      verdict.captured = 1'b0;
      held_state = st;
    end
  endtask

  // Track register writes, check result beats, queue predictions for sample beats
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs.lr_threshold = LR_THRESHOLD_RST;
      regs.fh_threshold = FH_THRESHOLD_RST;
      regs.min_run      = MIN_RUN_RST;
      roll_ref   = '0;
      pitch_ref  = '0;
      lr_count   = '0;
      fh_count   = '0;
      lr_neg     = 1'b0;
      fh_neg     = 1'b0;
      held_state = ST_NORMAL;
      predicted_states.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_LR_THRESHOLD: regs.lr_threshold = cfg.data;
          CFG_FH_THRESHOLD: regs.fh_threshold = cfg.data;
          CFG_MIN_RUN:      regs.min_run      = cfg.data[RUN_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (predicted_states.size() == 0) begin
          $error("result beat with no sample outstanding: balance_state %0d",
                 result.balance_state);
          mismatch_tally++;
        end else begin
          want = predicted_states.pop_front();
          if (result.balance_state !== want.state) begin
            $error("balance_state: expected %0d, got %0d", want.state,
                   result.balance_state);
            mismatch_tally++;
          end
          if (result.entered_imbalance !== want.entered) begin
            $error("entered_imbalance: expected %0b, got %0b", want.entered,
                   result.entered_imbalance);
            mismatch_tally++;
          end
          if (result.baseline_captured !== want.captured) begin
            $error("baseline_captured: expected %0b, got %0b", want.captured,
                   result.baseline_captured);
            mismatch_tally++;
          end
        end
      end
      if (sample.valid && sample.ready) begin
        classify_tilt(sample.roll_sample, sample.pitch_sample, sample.window_start, want);
        predicted_states.push_back(want);
      end
    end
    outstanding <= predicted_states.size();
  end

endmodule

/* verif/tb_tilt_imbalance_classifier_unit.sv */
// Testbench top for the tilt imbalance classifier: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on tic_pkg, tic_ifs, the unit itself and tic_balance_checker.
`timescale 1ns / 1ps

module tb_tilt_imbalance_classifier_unit;
  import tic_pkg::*;

  localparam int ANGLE_MAX = 32767;
  localparam int ANGLE_MIN = -32768;

  logic clk;
  logic rst;
  int   outstanding;
  int   mismatches;

  // Stimulus view of the current baseline and limits, used to aim offsets
  logic signed [ANGLE_W-1:0] aim_roll;
  logic signed [ANGLE_W-1:0] aim_pitch;
  logic [THR_W-1:0]          lr_lim;
  logic [THR_W-1:0]          fh_lim;
  logic [RUN_W-1:0]          run_goal;
  int                        burst_left;

  // Receiver stall pattern state
  int   rx_cycle = 0;
  int   rx_hold = 0;
  logic rx_level;

  tic_sample_if sample_ch ();
  tic_result_if result_ch ();
  tic_cfg_if    cfg_ch ();

  tilt_imbalance_classifier_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  tic_balance_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Stall the result channel: free-flowing, choppy and long-stall stretches
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      case ((rx_cycle / 400) % 3)
        0: begin
          rx_level = 1'b1;
          rx_hold  = $urandom_range(1, 8);
        end
        1: begin
          rx_level = 1'($urandom_range(0, 1));
          rx_hold  = $urandom_range(1, 5);
        end
        default: begin
          rx_level = ($urandom_range(0, 5) != 0);
          rx_hold  = rx_level ? $urandom_range(1, 15) : $urandom_range(8, 24);
        end
      endcase
    end else begin
      rx_hold--;
    end
    rx_cycle++;
    result_ch.ready <= rx_level;
  end

  // Offer one sample and hold it until the beat; close bursts with a random gap
  task automatic put_sample(input logic signed [ANGLE_W-1:0] roll,
                            input logic signed [ANGLE_W-1:0] pitch, input logic ws);
    int gap;
    sample_ch.valid        <= 1'b1;
    sample_ch.roll_sample  <= roll;
    sample_ch.pitch_sample <= pitch;
    sample_ch.window_start <= ws;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    if (ws) begin
      aim_roll  = roll;
      aim_pitch = pitch;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
  endtask

  // Drop valid and hold until every predicted verdict has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  // Load all three registers once the pipeline is empty
  task automatic load_config(input logic [THR_W-1:0] lr, input logic [THR_W-1:0] fh,
                             input logic [RUN_W-1:0] min_len);
    drain_results();
    cfg_beat(CFG_LR_THRESHOLD, lr);
    cfg_beat(CFG_FH_THRESHOLD, fh);
    cfg_beat(CFG_MIN_RUN, {8'($urandom_range(0, 255)), min_len});
    cfg_ch.valid <= 1'b0;
    lr_lim   = lr;
    fh_lim   = fh;
    run_goal = min_len;
  endtask

  // Pick one axis value around the baseline, over or within its limit
  function automatic logic signed [ANGLE_W-1:0] aim_axis(
      input logic signed [ANGLE_W-1:0] base, input logic [THR_W-1:0] limit, input bit over);
    int mag;
    int v;
    mag = over ? int'(limit) + 1 + $urandom_range(0, 40) : $urandom_range(0, limit);
    if ($urandom_range(0, 1)) mag = -mag;
    v = int'(base) + mag;
    if (v > ANGLE_MAX || v < ANGLE_MIN) v = int'(base) - mag;
    if (v > ANGLE_MAX) v = ANGLE_MAX;
    else if (v < ANGLE_MIN) v = ANGLE_MIN;
    return v[ANGLE_W-1:0];
  endfunction

  // Send a stretch of samples aimed over or under each limit; jitter breaks runs
  task automatic run_stretch(input int len, input bit lr_over, input bit fh_over,
                             input bit jitter);
    bit lr_bit;
    bit fh_bit;
    for (int i = 0; i < len; i++) begin
      lr_bit = lr_over ^ (jitter && $urandom_range(0, 19) == 0);
      fh_bit = fh_over ^ (jitter && $urandom_range(0, 19) == 0);
      put_sample(aim_axis(aim_roll, lr_lim, lr_bit), aim_axis(aim_pitch, fh_lim, fh_bit),
                 1'b0);
    end
  endtask

  // Mostly windows followed by aimed stretches, with some noise and restarts
  task automatic random_phase(input int n_items);
    int sent;
    int pick;
    int len;
    int seg_max;
    seg_max = (int'(run_goal) * 2 + 4 > 60) ? 60 : int'(run_goal) * 2 + 4;
    put_sample(16'($urandom), 16'($urandom), 1'b1);
    sent = 1;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        put_sample(16'($urandom), 16'($urandom), 1'b1);
        sent++;
      end else if (pick < 20) begin
        put_sample(16'($urandom), 16'($urandom), $urandom_range(0, 15) == 0);
        sent++;
      end else begin
        len = $urandom_range(1, seg_max);
        run_stretch(len, $urandom_range(0, 9) < 6, $urandom_range(0, 9) < 6, 1'b1);
        sent += len;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.roll_sample  = '0;
    sample_ch.pitch_sample = '0;
    sample_ch.window_start = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = CFG_LR_THRESHOLD;
    cfg_ch.data            = '0;
    result_ch.ready        = 1'b0;
    aim_roll   = '0;
    aim_pitch  = '0;
    lr_lim     = LR_THRESHOLD_RST;
    fh_lim     = FH_THRESHOLD_RST;
    run_goal   = MIN_RUN_RST;
    burst_left = 4;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset limits, no window yet: offsets are taken from a zero baseline
    put_sample(16'sd300, 16'sd0, 1'b0);
    put_sample(-16'sd300, 16'sd0, 1'b0);
    put_sample(16'sd0, 16'sd0, 1'b0);
    put_sample(16'sh7FFF, 16'sh8000, 1'b0);
    // Full-scale offsets from an extreme baseline
    put_sample(16'sh8000, 16'sh8000, 1'b1);
    put_sample(16'sh7FFF, 16'sh7FFF, 1'b0);

    // Limits at the top: a full-scale offset only clears a limit one below it
    load_config(16'hFFFF, 16'hFFFE, 8'd1);
    put_sample(16'sh8000, 16'sh7FFF, 1'b1);
    put_sample(16'sh7FFF, 16'sh8000, 1'b0);
    put_sample(16'sh8000, 16'sh7FFF, 1'b0);

    // Zero limits: walk through every direction, ties and a mid-stream restart
    load_config(16'h0000, 16'h0000, 8'd1);
    put_sample(16'sd0, 16'sd0, 1'b1);
    put_sample(16'sd1, 16'sd0, 1'b0);
    put_sample(-16'sd1, 16'sd0, 1'b0);
    put_sample(-16'sd1, -16'sd1, 1'b0);
    put_sample(16'sd0, 16'sd5, 1'b0);
    put_sample(16'sd0, -16'sd5, 1'b0);
    put_sample(16'sd3, -16'sd3, 1'b0);
    put_sample(16'sd0, 16'sd0, 1'b0);
    put_sample(16'sd7, 16'sd7, 1'b1);
    put_sample(16'sd7, 16'sd7, 1'b0);

    // Zero run length: every non-baseline sample reads as an imbalance
    load_config(FH_THRESHOLD_RST, FH_THRESHOLD_RST, 8'd0);
    put_sample(16'sd0, 16'sd0, 1'b0);
    put_sample(-16'sd1000, 16'sd1000, 1'b0);

    // Random phases over a spread of register settings
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: load_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       8'($urandom_range(1, 12)));
        1: load_config(16'h0000, 16'h0000, 8'd1);
        2: load_config(16'hFFFF, 16'hFFFF, 8'hFF);
        3: load_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 8'd0);
        4: load_config(16'hFFFF, 16'($urandom_range(0, 300)), 8'($urandom_range(1, 6)));
        5: load_config(16'($urandom_range(50, 500)), 16'($urandom_range(50, 500)), 8'hFF);
        6: load_config(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
        default: load_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                             8'($urandom_range(1, 30)));
      endcase
      if (ph == 5) begin
        // Saturate both counters together, then hold only front-hind at the top
        put_sample(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)), 1'b1);
        run_stretch(270, 1'b1, 1'b1, 1'b0);
        run_stretch(270, 1'b0, 1'b1, 1'b0);
      end else begin
        random_phase(ph == 2 ? 30 : 50);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tic_pkg.sv
rtl/core/tic_ifs.sv
rtl/core/tic_cfg_regs.sv
rtl/core/tic_classifier.sv
rtl/core/tilt_imbalance_classifier_unit.sv
verif/tic_balance_checker.sv
verif/tb_tilt_imbalance_classifier_unit.sv
